// File: src/smv_pkg.sv
package smv_pkg;

    localparam int WINDOW_MAX = 32;
    localparam int CLASS_BITS = 8;
    localparam int CNT_BITS   = $clog2(WINDOW_MAX + 1);
    localparam int IDX_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    localparam logic [5:0] WINDOW_RESET = 6'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_WAIT
    } smv_state_t;

endpackage

// File: src/sliding_majority_vote_core.sv
// Sliding-window majority vote over a stream of class labels.
// Input channel (in_valid/in_ready, class_in): one label per transaction.
// The label joins a history of the most recent window_length labels; once the
// history is full the oldest label is dropped.
// Output channel (out_valid/out_ready): voted_class is the most frequent label
// in the history (on a tie, the one that first appears oldest), vote_count its
// number of votes and window_fill the number of labels held.
// Configuration channel (cfg_valid/cfg_ready, window_length): sets the window,
// 0 acts as 1 and values above 32 act as 32; every write empties the history.
// Write it only while the block is idle.
// Timing: after a label is taken, one candidate a cycle is compared against
// the whole history by a shared compare-and-count unit, one candidate for
// each label held, and the result is loaded into the output register when
// the last candidate is done. The next label is taken as soon as
// the count ends, even while the result still waits in the output register.
// A stalled receiver holds the result; a finished count then waits until the
// output register is free. Reset empties the history and sets the window to 5.
module sliding_majority_vote_core
    import smv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] class_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] voted_class,
    output logic [5:0] vote_count,
    output logic [5:0] window_fill,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] window_length
);

    smv_state_t state_reg, state_next;

    logic [5:0]            window_reg, window_next;
    logic [CNT_BITS-1:0]   fill_reg, fill_next;
    logic [IDX_BITS-1:0]   cand_idx_reg, cand_idx_next;
    logic [CLASS_BITS-1:0] best_class_reg, best_class_next;
    logic [CNT_BITS-1:0]   best_cnt_reg, best_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            voted_reg, voted_next;
    logic [5:0]            vote_count_reg, vote_count_next;
    logic [5:0]            fill_out_reg, fill_out_next;

    logic [CLASS_BITS-1:0] hist_reg  [WINDOW_MAX];
    logic [CLASS_BITS-1:0] hist_next [WINDOW_MAX];

    logic                  in_accept;
    logic                  cfg_accept;
    logic [6:0]            wl_ext;
    logic [CNT_BITS-1:0]   win_eff;
    logic                  hist_full;
    logic [CNT_BITS-1:0]   wr_idx;
    logic [15:0]           class_wide;
    logic [CLASS_BITS-1:0] label;
    logic [CLASS_BITS-1:0] cand;
    logic [WINDOW_MAX-1:0] match_vec;
    logic [CNT_BITS-1:0]   match_cnt;
    logic                  last_cand;
    logic                  out_free;
    logic                  out_load;
    logic [15:0]           best_class_wide;
    logic [15:0]           best_cnt_wide;
    logic [15:0]           fill_wide;

    assign in_accept  = in_valid && in_ready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == ST_IDLE);

    // clamp the window to 1..WINDOW_MAX
    assign wl_ext = 7'(window_reg);
    always_comb
    begin
        if (window_reg == 6'd0)
        begin
            win_eff = CNT_BITS'(1);
        end
        else if (wl_ext > 7'(WINDOW_MAX))
        begin
            win_eff = CNT_BITS'(WINDOW_MAX);
        end
        else
        begin
            win_eff = CNT_BITS'(window_reg);
        end
    end

    assign hist_full  = (fill_reg >= win_eff);
    assign wr_idx     = hist_full ? (win_eff - CNT_BITS'(1)) : fill_reg;
    assign class_wide = 16'(class_in);
    assign label      = class_wide[CLASS_BITS-1:0];

    // history: append while filling, else shift towards index 0 and add at the top
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_hist
            logic [CLASS_BITS-1:0] upper;
            if (gi < WINDOW_MAX - 1)
            begin : g_up
                assign upper = hist_reg[gi+1];
            end
            else
            begin : g_top
                assign upper = hist_reg[gi];
            end

            always_comb
            begin
                hist_next[gi] = hist_reg[gi];
                if (in_accept)
                begin
                    if (CNT_BITS'(gi) == wr_idx)
                    begin
                        hist_next[gi] = label;
                    end
                    else if (hist_full && (CNT_BITS'(gi) < wr_idx))
                    begin
                        hist_next[gi] = upper;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                hist_reg[gi] <= hist_next[gi];
            end

            assign match_vec[gi] = (hist_reg[gi] == cand) && (CNT_BITS'(gi) < fill_reg);
        end
    endgenerate

    // shared compare-and-count unit: one candidate against the whole history
    assign cand      = hist_reg[cand_idx_reg];
    assign match_cnt = CNT_BITS'($countones(match_vec));
    assign last_cand = ((CNT_BITS'(cand_idx_reg) + CNT_BITS'(1)) == fill_reg);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        window_next     = window_reg;
        fill_next       = fill_reg;
        cand_idx_next   = cand_idx_reg;
        best_class_next = best_class_reg;
        best_cnt_next   = best_cnt_reg;
        out_load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    fill_next       = hist_full ? win_eff : (fill_reg + CNT_BITS'(1));
                    cand_idx_next   = '0;
                    best_class_next = label;
                    best_cnt_next   = '0;
                    state_next      = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                // strict compare keeps the oldest candidate on a tie
                if (match_cnt > best_cnt_reg)
                begin
                    best_class_next = cand;
                    best_cnt_next   = match_cnt;
                end
                if (last_cand)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
                else
                begin
                    cand_idx_next = cand_idx_reg + IDX_BITS'(1);
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_accept)
        begin
            window_next = window_length;
            fill_next   = '0;
        end
    end

    assign best_class_wide = 16'(best_class_next);
    assign best_cnt_wide   = 16'(best_cnt_next);
    assign fill_wide       = 16'(fill_reg);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        voted_next      = voted_reg;
        vote_count_next = vote_count_reg;
        fill_out_next   = fill_out_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            voted_next      = best_class_wide[7:0];
            vote_count_next = best_cnt_wide[5:0];
            fill_out_next   = fill_wide[5:0];
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            fill_reg      <= '0;
            cand_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            cand_idx_reg  <= cand_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_class_reg <= best_class_next;
        best_cnt_reg   <= best_cnt_next;
        voted_reg      <= voted_next;
        vote_count_reg <= vote_count_next;
        fill_out_reg   <= fill_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign voted_class = voted_reg;
    assign vote_count  = vote_count_reg;
    assign window_fill = fill_out_reg;

`ifndef ASSERT_OFF
    a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= win_eff)
        else $error("history fill exceeds window");

    a_cand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COUNT) |-> (CNT_BITS'(cand_idx_reg) < fill_reg))
        else $error("candidate index beyond history fill");

    a_accept_starts_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_COUNT) && (fill_reg != '0))
        else $error("accepted label did not start a count");

    a_votes_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (vote_count != 6'd0) && (vote_count <= window_fill))
        else $error("vote count out of range");

    a_wait_holds_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |-> out_valid)
        else $error("waiting with free output register");
`endif

endmodule
